>>> design/csbd_pkg.sv
// Package for the current-sense busy detector.
// Holds the request and result payload types, opcode and phase codes.
`timescale 1ns / 1ps

package csbd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int HOLD_BITS   = 16;
	localparam int APB_AW      = 2;

	// Byte address of hold_ticks
	localparam logic [APB_AW-1:0] ADDR_HOLD_TICKS = 2'd0;
	localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RESET = 16'd1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_PHASE  = 2'd2,
		OP_HOST   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_INIT = 2'd0,
		PH_IDLE = 2'd1,
		PH_FEED = 2'd2,
		PH_OPER = 2'd3
	} phase_t;

	typedef struct packed {
		op_t                    op;
		logic [SAMPLE_BITS-1:0] current;
		phase_t                 phase;
	} in_t;

	typedef struct packed {
		logic                   busy_res;
		logic [SAMPLE_BITS-1:0] threshold;
	} out_t;

endpackage

>>> design/csbd_cfg.sv
// APB register file of the busy detector: holds hold_ticks.
// Depends on csbd_pkg.
`timescale 1ns / 1ps

module csbd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [csbd_pkg::APB_AW-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [csbd_pkg::HOLD_BITS-1:0]      hold_ticks
);

	logic [csbd_pkg::HOLD_BITS-1:0] hold_ticks_q;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == csbd_pkg::ADDR_HOLD_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= csbd_pkg::HOLD_TICKS_RESET;
		end else if (wr_en) begin
			hold_ticks_q <= pwdata[csbd_pkg::HOLD_BITS-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == csbd_pkg::ADDR_HOLD_TICKS) begin
			prdata = {{(32 - csbd_pkg::HOLD_BITS){1'b0}}, hold_ticks_q};
		end
	end

	assign hold_ticks = hold_ticks_q;

endmodule

>>> design/csbd_in_stage.sv
// Input register of the busy detector: captures one request per cycle
// while in_stall is low. Depends on csbd_pkg.
`timescale 1ns / 1ps

module csbd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  csbd_pkg::in_t  in_data,
	input  logic           take,
	output logic           valid_s1,
	output csbd_pkg::in_t  item_s1
);

	logic          valid_s1_r;
	csbd_pkg::in_t item_s1_r;
	logic          load;

	// Hold the staged request while the result register is blocked
	assign in_stall = valid_s1_r && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (!in_stall) begin
			valid_s1_r <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1_r <= in_data;
		end
	end

	assign valid_s1 = valid_s1_r;
	assign item_s1  = item_s1_r;

endmodule

>>> design/csbd_core.sv
// Phase, peak, threshold and hold state of the busy detector, plus the
// result register. Depends on csbd_pkg.
`timescale 1ns / 1ps

module csbd_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s1,
	input  csbd_pkg::in_t                      item_s1,
	output logic                               take,
	input  logic [csbd_pkg::HOLD_BITS-1:0]     hold_ticks,
	output logic                               out_valid,
	input  logic                               out_stall,
	output csbd_pkg::out_t                     out_data
);

	localparam int SB = csbd_pkg::SAMPLE_BITS;
	localparam int HB = csbd_pkg::HOLD_BITS;

	csbd_pkg::phase_t phase_q, phase_d;
	logic [SB-1:0]    idle_peak_q, idle_peak_d;
	logic [SB-1:0]    feed_peak_q, feed_peak_d;
	logic [SB-1:0]    thr_q, thr_d;
	logic             busy_q, busy_d;
	logic [HB-1:0]    hold_cnt_q, hold_cnt_d;
	logic             hold_run_q, hold_run_d;
	logic [SB:0]      peak_sum;
	logic             advance;

	logic           out_valid_q;
	csbd_pkg::out_t out_data_q;

	assign take    = !(out_valid_q && out_stall);
	assign advance = valid_s1 && take;

	assign peak_sum = {1'b0, idle_peak_q} + {1'b0, feed_peak_q};

	always_comb begin
		phase_d     = phase_q;
		idle_peak_d = idle_peak_q;
		feed_peak_d = feed_peak_q;
		thr_d       = thr_q;
		busy_d      = busy_q;
		hold_cnt_d  = hold_cnt_q;
		hold_run_d  = hold_run_q;
		case (item_s1.op)
			csbd_pkg::OP_SAMPLE: begin
				case (phase_q)
					csbd_pkg::PH_IDLE: begin
						if (item_s1.current > idle_peak_q) idle_peak_d = item_s1.current;
					end
					csbd_pkg::PH_FEED: begin
						if (item_s1.current > feed_peak_q) feed_peak_d = item_s1.current;
					end
					csbd_pkg::PH_OPER: begin
						// Restart the hold on every over-threshold sample
						if (item_s1.current > thr_q) begin
							busy_d     = 1'b1;
							hold_cnt_d = hold_ticks;
							hold_run_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			csbd_pkg::OP_TICK: begin
				if (hold_run_q) begin
					if (hold_cnt_q <= HB'(1)) begin
						hold_cnt_d = '0;
						hold_run_d = 1'b0;
						if (phase_q == csbd_pkg::PH_OPER) busy_d = 1'b0;
					end else begin
						hold_cnt_d = hold_cnt_q - HB'(1);
					end
				end
			end
			csbd_pkg::OP_PHASE: begin
				phase_d = item_s1.phase;
				if (item_s1.phase == csbd_pkg::PH_OPER) begin
					thr_d  = peak_sum[SB:1];
					busy_d = 1'b0;
				end
			end
			csbd_pkg::OP_HOST: begin
				busy_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= csbd_pkg::PH_INIT;
			idle_peak_q <= '0;
			feed_peak_q <= '0;
			thr_q       <= '0;
			busy_q      <= 1'b1;
			hold_cnt_q  <= '0;
			hold_run_q  <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			idle_peak_q <= idle_peak_d;
			feed_peak_q <= feed_peak_d;
			thr_q       <= thr_d;
			busy_q      <= busy_d;
			hold_cnt_q  <= hold_cnt_d;
			hold_run_q  <= hold_run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.busy_res  <= busy_d;
			out_data_q.threshold <= thr_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/current_sense_busy_detector.sv
// Top level of the current-sense busy detector.
// Depends on csbd_pkg, csbd_cfg, csbd_in_stage and csbd_core.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in       | to block  | in_valid/in_stall  | in_data  (op, current, phase)
//   out      | from block| out_valid/out_stall| out_data (busy_res, threshold)
//   apb      | to block  | psel/penable/pready| hold_ticks at byte address 0
//
// One request per cycle while in_stall is low; each accepted request goes
// through the input register, then the state update writes its result into
// the result register, where it waits until taken.
// Reset loads phase init, busy set, peaks, threshold and hold cleared and
// hold_ticks = 1; no clearing pass is needed.
// A stalled result holds the result register; the input register then
// fills and in_stall rises one request later.
`timescale 1ns / 1ps

module current_sense_busy_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  csbd_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output csbd_pkg::out_t                  out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [csbd_pkg::APB_AW-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic [csbd_pkg::HOLD_BITS-1:0] hold_ticks;
	logic                           valid_s1;
	csbd_pkg::in_t                  item_s1;
	logic                           take;

	csbd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.hold_ticks (hold_ticks)
	);

	csbd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	csbd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.take       (take),
		.hold_ticks (hold_ticks),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

>>> design/csbd_checker.sv
// Port-level checks for the busy detector, bound to the top level.
// Depends on csbd_pkg and current_sense_busy_detector.
`timescale 1ns / 1ps

module csbd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input csbd_pkg::out_t  out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A result leaves only when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

	// Requests back up only behind a blocked result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled with free result register");

	// A fresh result follows an accepted request through the input register
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without request");

endmodule

bind current_sense_busy_detector csbd_checker u_csbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/current_sense_busy_detector_tb.sv
// Self-checking bench for current_sense_busy_detector: directed and random requests,
// hold_ticks writes over APB, results checked against an in-bench busy/threshold tracker.
// Depends on csbd_pkg and the current_sense_busy_detector RTL.
`timescale 1ns / 1ps

module current_sense_busy_detector_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP   = 100;
	localparam int SB          = csbd_pkg::SAMPLE_BITS;
	localparam int HB          = csbd_pkg::HOLD_BITS;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	csbd_pkg::in_t                  in_data   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	csbd_pkg::out_t                 out_data;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [csbd_pkg::APB_AW-1:0]    paddr     = '0;
	logic [31:0]                    pwdata    = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	// tracked detector state
	csbd_pkg::phase_t       phase_now   = csbd_pkg::PH_INIT;
	logic [SB-1:0]          idle_max    = '0;
	logic [SB-1:0]          feed_max    = '0;
	logic [SB-1:0]          thresh      = '0;
	logic                   busy        = 1'b1;
	logic [HB-1:0]          hold_left   = '0;
	logic                   hold_on     = 1'b0;
	logic [HB-1:0]          hold_len    = csbd_pkg::HOLD_TICKS_RESET;

	csbd_pkg::out_t         awaited_status[$];
	int                     mismatches  = 0;
	int                     items_sent  = 0;
	int unsigned            send_gap_pct = 0;
	int unsigned            stall_pct    = 0;
	int                     peak_cap     = 700;
	int                     quiet_cycles = 0;

	current_sense_busy_detector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the tracked state by one request and return the status it leaves.
	function automatic csbd_pkg::out_t busy_after(input csbd_pkg::in_t req);
		csbd_pkg::out_t res;
		logic [SB:0]    peak_sum;
		case (req.op)
			csbd_pkg::OP_SAMPLE: begin
				case (phase_now)
					csbd_pkg::PH_IDLE: if (req.current > idle_max) idle_max = req.current;
					csbd_pkg::PH_FEED: if (req.current > feed_max) feed_max = req.current;
					csbd_pkg::PH_OPER: begin
						if (req.current > thresh) begin
							busy      = 1'b1;
							hold_left = hold_len;
							hold_on   = 1'b1;
						end
					end
					default: ;
				endcase
			end
			csbd_pkg::OP_TICK: begin
				if (hold_on) begin
					if (hold_left <= 1) begin
						hold_left = '0;
						hold_on   = 1'b0;
						if (phase_now == csbd_pkg::PH_OPER) busy = 1'b0;
					end else begin
						hold_left = hold_left - 1'b1;
					end
				end
			end
			csbd_pkg::OP_PHASE: begin
				phase_now = req.phase;
				if (phase_now == csbd_pkg::PH_OPER) begin
					peak_sum = {1'b0, idle_max} + {1'b0, feed_max};
					thresh   = peak_sum[SB:1];
					busy     = 1'b0;
				end
			end
			default: busy = 1'b1;
		endcase
		res.busy_res  = busy;
		res.threshold = thresh;
		return res;
	endfunction

	// Keep measuring-phase samples at or below the cap so the peaks climb slowly.
	function automatic logic [SB-1:0] draw_current();
		if (phase_now == csbd_pkg::PH_IDLE || phase_now == csbd_pkg::PH_FEED)
			return SB'($urandom_range(0, peak_cap));
		return SB'($urandom_range(0, (1 << SB) - 1));
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Send one request; fields the op does not use carry random values.
	task automatic send_request(input csbd_pkg::op_t op, input logic [SB-1:0] cur,
			input csbd_pkg::phase_t ph);
		csbd_pkg::in_t req;
		req.op      = op;
		req.current = (op == csbd_pkg::OP_SAMPLE) ? cur : SB'($urandom());
		req.phase   = (op == csbd_pkg::OP_PHASE) ? ph :
			csbd_pkg::phase_t'($urandom_range(3));
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		awaited_status.push_back(busy_after(req));
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_hold_ticks(input logic [HB-1:0] ticks);
		wait_drained();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= csbd_pkg::ADDR_HOLD_TICKS;
		pwdata  <= {{(32 - HB){1'b0}}, ticks};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		hold_len = ticks;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic test_directed();
		send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);      // tick with no hold running
		send_request(csbd_pkg::OP_SAMPLE, 12'd4095, csbd_pkg::PH_INIT); // sample while initializing
		send_request(csbd_pkg::OP_HOST, '0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_IDLE);
		send_request(csbd_pkg::OP_SAMPLE, 12'd0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_SAMPLE, 12'd300, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_SAMPLE, 12'd200, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_FEED);
		send_request(csbd_pkg::OP_SAMPLE, 12'd500, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_OPER);
		send_request(csbd_pkg::OP_SAMPLE, 12'd400, csbd_pkg::PH_INIT); // equal to threshold
		send_request(csbd_pkg::OP_SAMPLE, 12'd0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_SAMPLE, 12'd401, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);      // hold expires
		send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_SAMPLE, 12'd4095, csbd_pkg::PH_INIT);
		// leave operating with hold running
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);      // expires but busy stays
		send_request(csbd_pkg::OP_SAMPLE, 12'd4095, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_HOST, '0, csbd_pkg::PH_INIT);
		// re-entry recomputes threshold
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_OPER);
		send_request(csbd_pkg::OP_HOST, '0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);
		send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_OPER);
	endtask

	task automatic test_hold_length();
		logic [HB-1:0] lengths[6];
		int            n_ticks;
		lengths = '{16'd0, 16'd1, 16'd2, 16'd5, 16'hFFFF, 16'd3};
		foreach (lengths[i]) begin
			write_hold_ticks(lengths[i]);
			send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_OPER);
			send_request(csbd_pkg::OP_SAMPLE, (thresh == '1) ? thresh : thresh + 1'b1,
				csbd_pkg::PH_INIT);
			n_ticks = (lengths[i] > 8) ? 3 : lengths[i] + 1;
			repeat (n_ticks) send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);
			send_request(csbd_pkg::OP_HOST, '0, csbd_pkg::PH_INIT);
			send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);
		end
	endtask

	task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
			input int n_items, input int cap);
		int            stop_at;
		int            pick;
		logic [SB-1:0] cur;
		logic [HB-1:0] ticks;
		pick = $urandom_range(99);
		if (pick < 70)      ticks = HB'($urandom_range(1, 6));
		else if (pick < 85) ticks = '0;
		else if (pick < 95) ticks = HB'($urandom_range(7, 40));
		else                ticks = HB'($urandom());
		write_hold_ticks(ticks);
		send_gap_pct = gap;
		stall_pct    = stall;
		peak_cap     = cap;
		stop_at      = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				// well-formed calibration, then operating traffic
				send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_IDLE);
				repeat ($urandom_range(0, 4))
					send_request(csbd_pkg::OP_SAMPLE, draw_current(), csbd_pkg::PH_INIT);
				send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_FEED);
				repeat ($urandom_range(0, 4))
					send_request(csbd_pkg::OP_SAMPLE, draw_current(), csbd_pkg::PH_INIT);
				send_request(csbd_pkg::OP_PHASE, '0, csbd_pkg::PH_OPER);
				repeat ($urandom_range(5, 30)) begin
					pick = $urandom_range(99);
					if (pick < 40) begin
						case ($urandom_range(3))
							0:       cur = thresh;
							1:       cur = (thresh == '1) ? thresh : thresh + 1'b1;
							2:       cur = (thresh == '0) ? thresh : thresh - 1'b1;
							default: cur = draw_current();
						endcase
						send_request(csbd_pkg::OP_SAMPLE, cur, csbd_pkg::PH_INIT);
					end else if (pick < 85) begin
						send_request(csbd_pkg::OP_TICK, '0, csbd_pkg::PH_INIT);
					end else if (pick < 92) begin
						send_request(csbd_pkg::OP_HOST, '0, csbd_pkg::PH_INIT);
					end else begin
						send_request(csbd_pkg::OP_PHASE, '0,
							csbd_pkg::phase_t'($urandom_range(3)));
					end
				end
			end else begin
				repeat ($urandom_range(1, 8))
					send_request(csbd_pkg::op_t'($urandom_range(3)), draw_current(),
						csbd_pkg::phase_t'($urandom_range(3)));
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Compare each accepted result against the oldest pending status.
	always @(posedge clk) begin
		csbd_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_status.size() == 0) begin
				note_mismatch("result with no request pending", out_data.threshold, -1);
			end else begin
				want = awaited_status.pop_front();
				if (out_data.busy_res !== want.busy_res)
					note_mismatch("busy_res", out_data.busy_res, want.busy_res);
				if (out_data.threshold !== want.threshold)
					note_mismatch("threshold", out_data.threshold, want.threshold);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("current_sense_busy_detector_tb: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_hold_length();
		test_random_traffic(0, 0, 380, 700);
		test_random_traffic(45, 0, 380, 1200);
		test_random_traffic(0, 45, 380, 2000);
		test_random_traffic(20, 20, 380, 4095);
		wait_drained();
		if (mismatches == 0)
			$display("current_sense_busy_detector_tb: done, clean");
		else
			$display("current_sense_busy_detector_tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
design/csbd_pkg.sv
design/csbd_cfg.sv
design/csbd_in_stage.sv
design/csbd_core.sv
design/current_sense_busy_detector.sv
design/csbd_checker.sv
tb/current_sense_busy_detector_tb.sv
